// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the allocator modules.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Whenever the trigger holds, the condition holds in the cycle after it.
`define ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) else $error(msg);

`endif

// ===== hw/rtl/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;
	localparam int HEAP_BYTES  = 16777216;
	localparam int MAX_ENTRIES = 64;

	localparam int OFF_W = $clog2(HEAP_BYTES) + 1;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int AW    = 34;

	localparam int TYPE_W   = 2;
	localparam int OWNER_W  = 16;
	localparam int SIZE_W   = 25;
	localparam int ALIGN_W  = 5;
	localparam int STATUS_W = 2;
	localparam int BOFF_W   = 24;
	localparam int BBYTES_W = 25;

	localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_DEALLOC = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd2;

	typedef struct packed {
		logic               busy;
		logic [OWNER_W-1:0] owner;
		logic [OFF_W-1:0]   bytes;
		logic [OFF_W-1:0]   off;
	} entry_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_SIZE,
		DP_NEED,
		DP_RD_FIRST,
		DP_RD_NEXT,
		DP_FREE_ENTRY,
		DP_FIT_CAPTURE,
		DP_FIT_GAP,
		DP_FIT_REST,
		DP_TAIL_USED,
		DP_TAIL_POS,
		DP_TAIL_CHARGE,
		DP_TAIL_COMMIT,
		DP_CP_INIT,
		DP_CP_STEP,
		DP_CP_TAIL,
		DP_CP_FLUSH
	} dp_op_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ENTRY,
		RES_NEW,
		RES_FAIL_SPACE,
		RES_FAIL_OWNER
	} res_op_t;

	typedef struct packed {
		dp_op_t  op;
		res_op_t res;
		logic    push;
	} dp_cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic              owner_zero;
		logic              count_zero;
		logic              table_full;
		logic              cur_last;
		logic              cur_fit;
		logic              cur_owner_hit;
		logic              split_room;
		logic              tail_fits;
		logic              cp_entry_done;
		logic              split;
		logic              out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ffba_if.sv =====
`default_nettype none
interface ffba_req_if import ffba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [OWNER_W-1:0] owner_handle;
	logic [SIZE_W-1:0]  request_size;
	logic [ALIGN_W-1:0] align_log2;

	modport source (output valid, req_type, owner_handle, request_size, align_log2,
		input ready);
	modport sink (input valid, req_type, owner_handle, request_size, align_log2,
		output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BOFF_W-1:0]   block_offset;
	logic [BBYTES_W-1:0] block_bytes;

	modport source (output valid, status, block_offset, block_bytes, input ready);
	modport sink (input valid, status, block_offset, block_bytes, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffba_ram.sv =====
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ffba_datapath.sv =====
`default_nettype none
module ffba_datapath import ffba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [TYPE_W-1:0]   in_type,
	input  logic [OWNER_W-1:0]  in_owner,
	input  logic [SIZE_W-1:0]   in_size,
	input  logic [ALIGN_W-1:0]  in_align,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [BOFF_W-1:0]   out_offset,
	output logic [BBYTES_W-1:0] out_bytes
);
	`include "assert_macros.svh"

	localparam int EW = $bits(entry_t);
	localparam int ADDR_W = IDX_W + 1;
	localparam logic [1:0] PIECE_GAP  = 2'd0;
	localparam logic [1:0] PIECE_BUSY = 2'd1;
	localparam logic [1:0] PIECE_REST = 2'd2;

	function automatic logic [AW-1:0] round_up(input logic [AW-1:0] x,
		input logic [ALIGN_W-1:0] lg);
		logic [AW-1:0] m;
		m = (AW'(1) << lg) - AW'(1);
		return (x + m) & ~m;
	endfunction

	logic [TYPE_W-1:0]   type_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SIZE_W-1:0]   req_q;
	logic [ALIGN_W-1:0]  lg_q;
	logic [AW-1:0]       size_q;
	logic [AW-1:0]       need_q;
	logic [AW-1:0]       newoff_q;
	logic [AW-1:0]       g_q;
	logic [AW-1:0]       used_q;
	logic [AW-1:0]       charge_q;
	logic [OFF_W-1:0]    base_q;
	logic [OFF_W-1:0]    ebytes_q;
	logic [OFF_W-1:0]    rest_q;
	logic [IDX_W-1:0]    fidx_q;
	entry_t              pend_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [BOFF_W-1:0]   res_off_q;
	logic [BBYTES_W-1:0] res_bytes_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [BOFF_W-1:0]   out_off_q;
	logic [BBYTES_W-1:0] out_bytes_q;

	logic [CNT_W-1:0]    count_q;
	logic                bank_q;
	logic [OFF_W-1:0]    tail_q;
	logic                out_valid_q;
	logic                pend_v_q;
	logic                split_q;
	logic [1:0]          sub_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    w_q;

	logic                rd_en;
	logic [IDX_W-1:0]    rd_idx;
	logic [EW-1:0]       rd_raw;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	entry_t              wr_entry;
	entry_t              cur;
	entry_t              cand;
	entry_t              step_cand;
	logic                in_split;
	logic                piece_last;
	logic                cur_last;
	logic                merge;
	logic [AW-1:0]       align_a;

	assign cur = entry_t'(rd_raw);
	assign align_a = AW'(1) << lg_q;
	assign cur_last = (CNT_W'(j_q) + CNT_W'(1)) == count_q;
	assign in_split = split_q && (j_q == fidx_q);
	assign piece_last = !in_split || (sub_q == PIECE_REST);

	always_comb begin
		step_cand = cur;
		if (in_split) begin
			case (sub_q)
				PIECE_GAP: begin
					step_cand = '{busy: 1'b0, owner: '0, bytes: g_q[OFF_W-1:0],
						off: base_q};
				end
				PIECE_BUSY: begin
					step_cand = '{busy: 1'b1, owner: owner_q, bytes: size_q[OFF_W-1:0],
						off: newoff_q[OFF_W-1:0]};
				end
				default: begin
					step_cand = '{busy: 1'b0, owner: '0, bytes: rest_q,
						off: OFF_W'(newoff_q + size_q)};
				end
			endcase
		end
	end

	always_comb begin
		if (cmd.op == DP_CP_TAIL) begin
			cand = '{busy: 1'b1, owner: owner_q, bytes: size_q[OFF_W-1:0],
				off: newoff_q[OFF_W-1:0]};
		end else begin
			cand = step_cand;
		end
	end

	assign merge = pend_v_q && !pend_q.busy && !cand.busy &&
		(({1'b0, pend_q.off} + {1'b0, pend_q.bytes}) == {1'b0, cand.off});

	always_comb begin
		rd_en = 1'b0;
		rd_idx = '0;
		wr_en = 1'b0;
		wr_addr = {~bank_q, w_q};
		wr_entry = pend_q;
		case (cmd.op)
			DP_RD_FIRST, DP_NEED, DP_CP_INIT: begin
				rd_en = 1'b1;
			end
			DP_RD_NEXT: begin
				rd_en = 1'b1;
				rd_idx = j_q + IDX_W'(1);
			end
			DP_FREE_ENTRY: begin
				wr_en = 1'b1;
				wr_addr = {bank_q, j_q};
				wr_entry = cur;
				wr_entry.busy = 1'b0;
				wr_entry.owner = '0;
			end
			DP_CP_STEP: begin
				rd_en = piece_last && !cur_last;
				rd_idx = j_q + IDX_W'(1);
				wr_en = pend_v_q && !merge;
			end
			DP_CP_TAIL: begin
				wr_en = pend_v_q && !merge;
			end
			DP_CP_FLUSH: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(EW),
		.DEPTH(2 * MAX_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr({bank_q, rd_idx}),
		.rd_data(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q <= 1'b0;
			tail_q <= OFF_W'(HEAP_BYTES);
			out_valid_q <= 1'b0;
			pend_v_q <= 1'b0;
			split_q <= 1'b0;
			sub_q <= PIECE_GAP;
			j_q <= '0;
			w_q <= '0;
		end else begin
			case (cmd.op)
				DP_LOAD: split_q <= 1'b0;
				DP_RD_FIRST, DP_NEED: j_q <= '0;
				DP_RD_NEXT: j_q <= j_q + IDX_W'(1);
				DP_FIT_CAPTURE: split_q <= 1'b1;
				DP_TAIL_COMMIT: tail_q <= tail_q - charge_q[OFF_W-1:0];
				DP_CP_INIT: begin
					j_q <= '0;
					w_q <= '0;
					pend_v_q <= 1'b0;
					sub_q <= (g_q != '0) ? PIECE_GAP : PIECE_BUSY;
				end
				DP_CP_STEP, DP_CP_TAIL: begin
					pend_v_q <= 1'b1;
					if (pend_v_q && !merge) begin
						w_q <= w_q + IDX_W'(1);
					end
					if (cmd.op == DP_CP_STEP) begin
						if (!piece_last) begin
							sub_q <= sub_q + 2'd1;
						end else if (!cur_last) begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				DP_CP_FLUSH: begin
					count_q <= CNT_W'(w_q) + CNT_W'(1);
					bank_q <= ~bank_q;
				end
				default: begin
				end
			endcase
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				type_q <= in_type;
				owner_q <= in_owner;
				req_q <= in_size;
				lg_q <= in_align;
			end
			DP_SIZE: size_q <= round_up(AW'(req_q), lg_q);
			DP_NEED: need_q <= size_q + (align_a << 1);
			DP_FIT_CAPTURE: begin
				base_q <= cur.off;
				ebytes_q <= cur.bytes;
				fidx_q <= j_q;
				newoff_q <= round_up(AW'(cur.off), lg_q);
			end
			DP_FIT_GAP: g_q <= newoff_q - AW'(base_q);
			DP_FIT_REST: rest_q <= ebytes_q - size_q[OFF_W-1:0] - g_q[OFF_W-1:0];
			DP_TAIL_USED: used_q <= AW'(HEAP_BYTES) - AW'(tail_q);
			DP_TAIL_POS: newoff_q <= round_up(used_q, lg_q);
			DP_TAIL_CHARGE: charge_q <= size_q + (newoff_q - used_q);
			DP_CP_STEP, DP_CP_TAIL: begin
				if (merge) begin
					pend_q.bytes <= pend_q.bytes + cand.bytes;
				end else begin
					pend_q <= cand;
				end
			end
			default: begin
			end
		endcase
		case (cmd.res)
			RES_ENTRY: begin
				res_status_q <= ST_OK;
				res_off_q <= cur.off[BOFF_W-1:0];
				res_bytes_q <= BBYTES_W'(cur.bytes);
			end
			RES_NEW: begin
				res_status_q <= ST_OK;
				res_off_q <= newoff_q[BOFF_W-1:0];
				res_bytes_q <= size_q[BBYTES_W-1:0];
			end
			RES_FAIL_SPACE: begin
				res_status_q <= ST_NO_SPACE;
				res_off_q <= '0;
				res_bytes_q <= '0;
			end
			RES_FAIL_OWNER: begin
				res_status_q <= ST_NO_OWNER;
				res_off_q <= '0;
				res_bytes_q <= '0;
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_off_q <= res_off_q;
			out_bytes_q <= res_bytes_q;
		end
	end

	always_comb begin
		stat.req_type = type_q;
		stat.owner_zero = (owner_q == '0);
		stat.count_zero = (count_q == '0);
		stat.table_full = (count_q >= CNT_W'(MAX_ENTRIES));
		stat.cur_last = cur_last;
		stat.cur_fit = !cur.busy && (AW'(cur.bytes) >= need_q);
		stat.cur_owner_hit = cur.busy && (cur.owner == owner_q);
		stat.split_room = ({1'b0, count_q} +
			((g_q != '0) ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1))) <= (CNT_W + 1)'(MAX_ENTRIES);
		stat.tail_fits = (charge_q <= AW'(tail_q));
		stat.cp_entry_done = piece_last;
		stat.split = split_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_offset = out_off_q;
	assign out_bytes = out_bytes_q;

	`ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(MAX_ENTRIES), "Entry count exceeds the table.")
	`ASSERT_NEXT(a_flush_swaps, cmd.op == DP_CP_FLUSH, count_q != '0 && bank_q != $past(bank_q), "Rebuild did not commit the new table.")
	`ASSERT_ALWAYS(a_tail_range, tail_q <= OFF_W'(HEAP_BYTES), "Tail space exceeds the heap.")
endmodule
`default_nettype wire

// ===== hw/rtl/ffba_ctrl.sv =====
`default_nettype none
module ffba_ctrl import ffba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);
	`include "assert_macros.svh"

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_OWN_SCAN,
		S_SIZE,
		S_NEED,
		S_FIT_SCAN,
		S_FIT_GAP,
		S_FIT_REST,
		S_TAIL_USED,
		S_TAIL_POS,
		S_TAIL_CHARGE,
		S_TAIL_CHECK,
		S_CP_INIT,
		S_CP_RUN,
		S_CP_TAIL,
		S_CP_FLUSH,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '{op: DP_NOP, res: RES_NONE, push: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = DP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.req_type) inside
					REQ_ALLOC: begin
						if (stat.owner_zero) begin
							cmd.res = RES_FAIL_SPACE;
							state_d = S_RESULT;
						end else begin
							state_d = S_SIZE;
						end
					end
					REQ_DEALLOC, REQ_QUERY: begin
						if (stat.count_zero) begin
							cmd.res = RES_FAIL_OWNER;
							state_d = S_RESULT;
						end else begin
							cmd.op = DP_RD_FIRST;
							state_d = S_OWN_SCAN;
						end
					end
					default: begin
						cmd.res = RES_FAIL_OWNER;
						state_d = S_RESULT;
					end
				endcase
			end
			S_OWN_SCAN: begin
				if (stat.cur_owner_hit) begin
					cmd.res = RES_ENTRY;
					if (stat.req_type == REQ_DEALLOC) begin
						cmd.op = DP_FREE_ENTRY;
					end
					state_d = S_RESULT;
				end else if (stat.cur_last) begin
					cmd.res = RES_FAIL_OWNER;
					state_d = S_RESULT;
				end else begin
					cmd.op = DP_RD_NEXT;
				end
			end
			S_SIZE: begin
				cmd.op = DP_SIZE;
				state_d = S_NEED;
			end
			S_NEED: begin
				cmd.op = DP_NEED;
				state_d = stat.count_zero ? S_TAIL_USED : S_FIT_SCAN;
			end
			S_FIT_SCAN: begin
				if (stat.cur_fit) begin
					cmd.op = DP_FIT_CAPTURE;
					state_d = S_FIT_GAP;
				end else if (stat.cur_last) begin
					state_d = S_TAIL_USED;
				end else begin
					cmd.op = DP_RD_NEXT;
				end
			end
			S_FIT_GAP: begin
				cmd.op = DP_FIT_GAP;
				state_d = S_FIT_REST;
			end
			S_FIT_REST: begin
				cmd.op = DP_FIT_REST;
				if (stat.split_room) begin
					state_d = S_CP_INIT;
				end else begin
					cmd.res = RES_FAIL_SPACE;
					state_d = S_RESULT;
				end
			end
			S_TAIL_USED: begin
				if (stat.table_full) begin
					cmd.res = RES_FAIL_SPACE;
					state_d = S_RESULT;
				end else begin
					cmd.op = DP_TAIL_USED;
					state_d = S_TAIL_POS;
				end
			end
			S_TAIL_POS: begin
				cmd.op = DP_TAIL_POS;
				state_d = S_TAIL_CHARGE;
			end
			S_TAIL_CHARGE: begin
				cmd.op = DP_TAIL_CHARGE;
				state_d = S_TAIL_CHECK;
			end
			S_TAIL_CHECK: begin
				if (stat.tail_fits) begin
					cmd.op = DP_TAIL_COMMIT;
					state_d = S_CP_INIT;
				end else begin
					cmd.res = RES_FAIL_SPACE;
					state_d = S_RESULT;
				end
			end
			S_CP_INIT: begin
				cmd.op = DP_CP_INIT;
				state_d = stat.count_zero ? S_CP_TAIL : S_CP_RUN;
			end
			S_CP_RUN: begin
				cmd.op = DP_CP_STEP;
				if (stat.cp_entry_done && stat.cur_last) begin
					state_d = stat.split ? S_CP_FLUSH : S_CP_TAIL;
				end
			end
			S_CP_TAIL: begin
				cmd.op = DP_CP_TAIL;
				state_d = S_CP_FLUSH;
			end
			S_CP_FLUSH: begin
				cmd.op = DP_CP_FLUSH;
				cmd.res = RES_NEW;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_push_free, !cmd.push || stat.out_free, "Result pushed over a waiting word.")
	`ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_q == S_DECODE, "Accepted word was not decoded.")
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator.sv =====
// Channel  Role    Words
// req      sink    req_type, owner_handle, request_size, align_log2
// rsp      source  status, block_offset, block_bytes
//
// One request is handled at a time; each gives exactly one response word.
// Deallocate and query scan the block table, one entry per cycle.
// Allocate scans for a fit, then rebuilds the table into the other memory bank
// with split and merge, at most one write per cycle.
// Reset clears the entry count and restores the full heap; no clearing pass is needed.
// A result waiting on rsp stalls only the end of the next request, not its acceptance.
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.cmd     (cmd),
		.stat    (stat)
	);

	ffba_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_type   (req.req_type),
		.in_owner  (req.owner_handle),
		.in_size   (req.request_size),
		.in_align  (req.align_log2),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_status(rsp.status),
		.out_offset(rsp.block_offset),
		.out_bytes (rsp.block_bytes)
	);
endmodule
`default_nettype wire
